// File: hw/rtl/salu_pkg.sv
// ----------------------------------------------------------------------------
// salu_pkg
// Shared opcodes, widths and pipeline payload types of the signed ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package salu_pkg;

  localparam int unsigned W = 32;
  localparam int unsigned OpW = 4;
  localparam int unsigned DivStages = (W + 1) / 2;
  localparam int unsigned MulW = 2 * W;
  localparam int unsigned HalfW = W / 2;

  typedef enum logic [OpW-1:0] {
    OpAdd = 4'd0, OpSub = 4'd1, OpMul = 4'd2, OpDiv = 4'd3, OpAnd = 4'd4,
    OpEq = 4'd5, OpNe = 4'd6, OpLt = 4'd7, OpGt = 4'd8, OpGti = 4'd9,
    OpLti = 4'd10, OpLd = 4'd11, OpSt = 4'd12, OpAddr = 4'd13,
    OpBad0 = 4'd14, OpBad1 = 4'd15
  } op_e;

  typedef struct packed {
    logic [W-1:0] res;
    logic         ovf;
    logic         is_div;
    logic         is_mul;
    logic         a_neg;
    logic         b_neg;
  } side_t;

endpackage

`default_nettype wire

// File: hw/rtl/signed_alu_with_overflow.sv
// ----------------------------------------------------------------------------
// signed_alu_with_overflow
// Pipelined 32-bit signed ALU with overflow flag.
//
// Input channel: in_valid_i/in_ready_o carry action_i, operand_a_i and
// operand_b_i. Output channel: out_valid_o/out_ready_i carry result_value_o
// and overflow_flag_o. One result beat per input beat, in order.
// Every operation runs through the same pipeline: a decode stage, sixteen
// divider stages of two quotient bits each (the multiplier partial products
// ride the last two of them), and a finishing stage.
// Throughput is one beat per cycle unless the receiver stalls. The whole pipeline advances together
// whenever the last stage is empty or its beat is taken, so a stalled
// receiver holds every stage and nothing is dropped or repeated.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_alu_with_overflow (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [salu_pkg::OpW-1:0]    action_i,
  input  wire logic [salu_pkg::W-1:0]      operand_a_i,
  input  wire logic [salu_pkg::W-1:0]      operand_b_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [salu_pkg::W-1:0]    result_value_o,
  output logic                             overflow_flag_o
);

  localparam int unsigned W = salu_pkg::W;
  localparam int unsigned N = salu_pkg::DivStages;
  localparam int unsigned H = salu_pkg::HalfW;

  logic adv;
  logic [N+1:0] vld_q;
  salu_pkg::side_t side_q [N+1];
  logic [W-1:0] rem_q [N+1];
  logic [W-1:0] quo_q [N+1];
  logic [W-1:0] dvs_q [N+1];
  logic [W-1:0] amag_q [N-1];
  logic [W-1:0] rem_n [N];
  logic [W-1:0] quo_n [N];
  logic [W-1:0] pp_q [4];
  logic [salu_pkg::MulW-1:0] prod_q;
  salu_pkg::side_t side_d;
  logic [W-1:0] a_mag, b_mag;
  logic signed [W:0] sum, dif;
  logic signed [W-1:0] sa, sb;
  logic [W-1:0] res_q;
  logic ovf_q;

  assign adv = !vld_q[N+1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    sa = operand_a_i;
    sb = operand_b_i;
    a_mag = sa[W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    b_mag = sb[W-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    sum = {sa[W-1], sa} + {sb[W-1], sb};
    dif = {sa[W-1], sa} - {sb[W-1], sb};
    side_d = '0;
    side_d.a_neg = sa[W-1];
    side_d.b_neg = sb[W-1];
    unique case (salu_pkg::op_e'(action_i))
      salu_pkg::OpAdd, salu_pkg::OpLd, salu_pkg::OpSt, salu_pkg::OpAddr: begin
        side_d.res = sum[W-1:0];
        side_d.ovf = sum[W] != sum[W-1];
      end
      salu_pkg::OpSub: begin
        side_d.res = dif[W-1:0];
        side_d.ovf = dif[W] != dif[W-1];
      end
      salu_pkg::OpMul: side_d.is_mul = 1'b1;
      salu_pkg::OpDiv: begin
        if (operand_b_i == '0) begin
          side_d.ovf = 1'b1;
        end else if (operand_a_i == {1'b1, {(W-1){1'b0}}} && operand_b_i == '1) begin
          side_d.ovf = 1'b1;
          side_d.res = operand_a_i;
        end else begin
          side_d.is_div = 1'b1;
        end
      end
      salu_pkg::OpAnd: side_d.res = operand_a_i & operand_b_i;
      salu_pkg::OpEq:  side_d.res = {{(W-1){1'b0}}, sa == sb};
      salu_pkg::OpNe:  side_d.res = {{(W-1){1'b0}}, sa != sb};
      salu_pkg::OpLt, salu_pkg::OpLti: side_d.res = {{(W-1){1'b0}}, sa < sb};
      salu_pkg::OpGt, salu_pkg::OpGti: side_d.res = {{(W-1){1'b0}}, sa > sb};
      salu_pkg::OpBad0, salu_pkg::OpBad1: side_d.ovf = 1'b1;
      default: side_d.ovf = 1'b1;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_div
    salu_div_stage u_stage (
      .rem_i(rem_q[i]), .quo_i(quo_q[i]), .dvs_i(dvs_q[i]),
      .rem_o(rem_n[i]), .quo_o(quo_n[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      rem_q[0]  <= '0;
      quo_q[0]  <= a_mag;
      dvs_q[0]  <= b_mag;
      amag_q[0] <= a_mag;
      for (int i = 0; i < N; i++) begin
        side_q[i+1] <= side_q[i];
        rem_q[i+1]  <= rem_n[i];
        quo_q[i+1]  <= quo_n[i];
        dvs_q[i+1]  <= dvs_q[i];
      end
      for (int i = 0; i < N - 2; i++) begin
        amag_q[i+1] <= amag_q[i];
      end
      pp_q[0] <= amag_q[N-2][H-1:0] * dvs_q[N-2][H-1:0];
      pp_q[1] <= amag_q[N-2][H-1:0] * dvs_q[N-2][W-1:H];
      pp_q[2] <= amag_q[N-2][W-1:H] * dvs_q[N-2][H-1:0];
      pp_q[3] <= amag_q[N-2][W-1:H] * dvs_q[N-2][W-1:H];
      prod_q <= {pp_q[3], pp_q[0]} + {{H{1'b0}}, pp_q[1], {H{1'b0}}}
              + {{H{1'b0}}, pp_q[2], {H{1'b0}}};
      if (side_q[N].is_div) begin
        res_q <= (side_q[N].a_neg ^ side_q[N].b_neg) ? (~quo_q[N] + 1'b1) : quo_q[N];
        ovf_q <= 1'b0;
      end else if (side_q[N].is_mul) begin
        res_q <= (side_q[N].a_neg ^ side_q[N].b_neg) ? (~prod_q[W-1:0] + 1'b1)
                                                      : prod_q[W-1:0];
        if (side_q[N].a_neg ^ side_q[N].b_neg) begin
          ovf_q <= prod_q > {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
        end else begin
          ovf_q <= prod_q[salu_pkg::MulW-1:W-1] != '0;
        end
      end else begin
        res_q <= side_q[N].res;
        ovf_q <= side_q[N].ovf;
      end
    end
  end

  assign out_valid_o = vld_q[N+1];
  assign result_value_o = res_q;
  assign overflow_flag_o = ovf_q;

  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("stalled result changed");
  ap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled while empty at output");
  ap_div_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(side_q[0].is_div && side_q[0].is_mul))
    else $error("divide and multiply both marked");

endmodule

`default_nettype wire

// File: hw/rtl/salu_div_stage.sv
// ----------------------------------------------------------------------------
// salu_div_stage
// Two restoring division steps on unsigned magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module salu_div_stage (
  input  wire logic [salu_pkg::W-1:0] rem_i,
  input  wire logic [salu_pkg::W-1:0] quo_i,
  input  wire logic [salu_pkg::W-1:0] dvs_i,
  output logic      [salu_pkg::W-1:0] rem_o,
  output logic      [salu_pkg::W-1:0] quo_o
);

  logic [salu_pkg::W:0] t0, t1;
  logic [salu_pkg::W-1:0] r1, q1;

  always_comb begin
    t0 = {rem_i, quo_i[salu_pkg::W-1]};
    if (t0 >= {1'b0, dvs_i}) begin
      t0 = t0 - {1'b0, dvs_i};
      q1 = {quo_i[salu_pkg::W-2:0], 1'b1};
    end else begin
      q1 = {quo_i[salu_pkg::W-2:0], 1'b0};
    end
    r1 = t0[salu_pkg::W-1:0];
    t1 = {r1, q1[salu_pkg::W-1]};
    if (t1 >= {1'b0, dvs_i}) begin
      t1 = t1 - {1'b0, dvs_i};
      quo_o = {q1[salu_pkg::W-2:0], 1'b1};
    end else begin
      quo_o = {q1[salu_pkg::W-2:0], 1'b0};
    end
    rem_o = t1[salu_pkg::W-1:0];
  end

endmodule

`default_nettype wire
